// ===== hdl/cmadj_pkg.sv =====
// Shared types and constants for the complex matrix adjoint product block.
package cmadj_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 28;
    localparam int PROD_W = 2 * DATA_W;
    localparam int TERM_W = PROD_W - FRAC_W;
    localparam int ELEM_W = 2 * DATA_W;

    typedef struct packed {
        logic signed [DATA_W-1:0] b_real;
        logic signed [DATA_W-1:0] b_imag;
        logic signed [DATA_W-1:0] c_real;
        logic signed [DATA_W-1:0] c_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] a_real;
        logic signed [DATA_W-1:0] a_imag;
        logic                     last_result;
        logic                     saturated;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MAC,
        ST_WAIT1,
        ST_WAIT2,
        ST_EMIT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // write the incoming element into both stores
        logic mac;    // read one term and push it down the MAC pipe
        logic first;  // this term starts a new result element
        logic emit;   // move the accumulated element into the output register
        logic last;   // element being emitted closes the matrix
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

// ===== hdl/cmadj_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cmadj_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 9
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/cmadj_ctrl.sv =====
// Controller: load sequencing and MAC/emit scheduling for the adjoint product.
module cmadj_ctrl import cmadj_pkg::*; #(
    parameter int DIM = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  t_dp_stat                     i_stat,
    output t_dp_cmd                      o_cmd,
    output logic [$clog2(DIM*DIM)-1:0]   o_waddr,
    output logic [$clog2(DIM*DIM)-1:0]   o_raddr_b,
    output logic [$clog2(DIM*DIM)-1:0]   o_raddr_c
);

    localparam int AW    = $clog2(DIM * DIM);
    localparam int IDX_W = $clog2(DIM);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_load_cnt, n_load_cnt;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;

    logic accept;
    logic load_done;
    logic k_last;
    logic elem_last;

    assign accept    = (r_state == ST_LOAD) && i_valid;
    assign load_done = (r_load_cnt == AW'(DIM * DIM - 1));
    assign k_last    = (r_k == IDX_W'(DIM - 1));
    assign elem_last = (r_i == IDX_W'(DIM - 1)) && (r_j == IDX_W'(DIM - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (accept && load_done) n_state = ST_MAC;
            end
            ST_MAC: begin
                if (k_last) n_state = ST_WAIT1;
            end
            ST_WAIT1: n_state = ST_WAIT2;
            ST_WAIT2: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_stat.out_free) n_state = elem_last ? ST_LOAD : ST_MAC;
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // counters
    always_comb begin
        n_load_cnt = r_load_cnt;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        case (r_state)
            ST_LOAD: begin
                if (accept) begin
                    n_load_cnt = load_done ? '0 : r_load_cnt + AW'(1);
                end
            end
            ST_MAC: begin
                n_k = k_last ? '0 : r_k + IDX_W'(1);
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    if (r_j == IDX_W'(DIM - 1)) begin
                        n_j = '0;
                        n_i = elem_last ? '0 : r_i + IDX_W'(1);
                    end else begin
                        n_j = r_j + IDX_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // outputs
    always_comb begin
        o_stall     = (r_state != ST_LOAD);
        o_cmd.load  = accept;
        o_cmd.mac   = (r_state == ST_MAC);
        o_cmd.first = (r_k == '0);
        o_cmd.emit  = (r_state == ST_EMIT) && i_stat.out_free;
        o_cmd.last  = elem_last;
    end

    assign o_waddr   = r_load_cnt;
    assign o_raddr_b = AW'(r_k * DIM + r_i);
    assign o_raddr_c = AW'(r_j * DIM + r_k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_load_cnt <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
        end
    end

    // the emit step is entered only once the last term has left the MAC pipe
    a_emit_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_EMIT) && ($past(r_state) == ST_WAIT2))
            |-> ($past(r_state, 3) == ST_MAC))
        else $error("emit before MAC pipe drained");

    a_k_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MAC) |-> (r_k == '0))
        else $error("term index not parked outside MAC");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_i <= IDX_W'(DIM - 1)) && (r_j <= IDX_W'(DIM - 1)))
        else $error("element index out of range");

endmodule

// ===== hdl/cmadj_dp.sv =====
// Datapath: element stores, complex MAC pipeline, saturation and output register.
module cmadj_dp import cmadj_pkg::*; #(
    parameter int DIM = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_in_item                     i_item,
    input  t_dp_cmd                      i_cmd,
    input  logic [$clog2(DIM*DIM)-1:0]   i_waddr,
    input  logic [$clog2(DIM*DIM)-1:0]   i_raddr_b,
    input  logic [$clog2(DIM*DIM)-1:0]   i_raddr_c,
    output t_dp_stat                     o_stat,
    input  logic                         i_stall,
    output logic                         o_valid,
    output t_out_item                    o_item
);

    localparam int DEPTH = DIM * DIM;
    localparam int ACC_W = TERM_W + 2 + $clog2(DIM);

    logic [ELEM_W-1:0] rd_b, rd_c;

    cmadj_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_waddr),
        .i_wdata ({i_item.b_imag, i_item.b_real}),
        .i_raddr (i_raddr_b),
        .o_rdata (rd_b)
    );

    cmadj_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_c_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load),
        .i_waddr (i_waddr),
        .i_wdata ({i_item.c_imag, i_item.c_real}),
        .i_raddr (i_raddr_c),
        .o_rdata (rd_c)
    );

    logic signed [DATA_W-1:0] br, bi, cr, ci;
    assign br = $signed(rd_b[DATA_W-1:0]);
    assign bi = $signed(rd_b[ELEM_W-1:DATA_W]);
    assign cr = $signed(rd_c[DATA_W-1:0]);
    assign ci = $signed(rd_c[ELEM_W-1:DATA_W]);

    // pipe tags: read data valid, then products valid
    logic r_rd_v, r_rd_first, r_p_v, r_p_first;
    logic signed [PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_p_v  <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.mac;
            r_p_v  <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= i_cmd.first;
        r_p_first  <= r_rd_first;
        r_p_rr     <= br * cr;
        r_p_ii     <= bi * ci;
        r_p_ri     <= br * ci;
        r_p_ir     <= bi * cr;
    end

    // floor shift is the upper bits of the two's complement product
    logic signed [TERM_W-1:0] s_rr, s_ii, s_ri, s_ir;
    logic signed [ACC_W-1:0]  e_rr, e_ii, e_ri, e_ir;
    logic signed [ACC_W-1:0]  term_re, term_im;

    assign s_rr = $signed(r_p_rr[PROD_W-1:FRAC_W]);
    assign s_ii = $signed(r_p_ii[PROD_W-1:FRAC_W]);
    assign s_ri = $signed(r_p_ri[PROD_W-1:FRAC_W]);
    assign s_ir = $signed(r_p_ir[PROD_W-1:FRAC_W]);
    assign e_rr = ACC_W'(s_rr);
    assign e_ii = ACC_W'(s_ii);
    assign e_ri = ACC_W'(s_ri);
    assign e_ir = ACC_W'(s_ir);
    assign term_re = e_rr - e_ii;
    assign term_im = -(e_ri + e_ir);

    logic signed [ACC_W-1:0] r_acc_re, r_acc_im;

    always_ff @(posedge i_clk) begin
        if (r_p_v) begin
            r_acc_re <= r_p_first ? term_re : r_acc_re + term_re;
            r_acc_im <= r_p_first ? term_im : r_acc_im + term_im;
        end
    end

    // clip to the 32-bit range: in range when all bits above bit 30 agree
    logic                     clip_re, clip_im;
    logic signed [DATA_W-1:0] sat_re, sat_im;
    logic [DATA_W-1:0]        pos_max, neg_min;

    assign pos_max = {1'b0, {(DATA_W-1){1'b1}}};
    assign neg_min = {1'b1, {(DATA_W-1){1'b0}}};
    assign clip_re = !((&r_acc_re[ACC_W-1:DATA_W-1]) || !(|r_acc_re[ACC_W-1:DATA_W-1]));
    assign clip_im = !((&r_acc_im[ACC_W-1:DATA_W-1]) || !(|r_acc_im[ACC_W-1:DATA_W-1]));
    assign sat_re  = clip_re ? $signed(r_acc_re[ACC_W-1] ? neg_min : pos_max)
                             : $signed(r_acc_re[DATA_W-1:0]);
    assign sat_im  = clip_im ? $signed(r_acc_im[ACC_W-1] ? neg_min : pos_max)
                             : $signed(r_acc_im[DATA_W-1:0]);

    logic      r_out_v;
    t_out_item r_out;

    assign o_stat.out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_v <= 1'b1;
        end else if (!i_stall) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.a_real      <= sat_re;
            r_out.a_imag      <= sat_im;
            r_out.last_result <= i_cmd.last;
            r_out.saturated   <= clip_re || clip_im;
        end
    end

    assign o_valid = r_out_v;
    assign o_item  = r_out;

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> r_out_v)
        else $error("pending result dropped");

    a_acc_after_terms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_v |-> $past(i_cmd.mac, 2))
        else $error("MAC pipe tag out of step");

endmodule

// ===== hdl/complex_matrix_adjoint_product.sv =====
// Top level: complex matrix product A = B-dagger * C-dagger in signed Q4.28.
//
//  channel | valid   | stall   | payload | direction
//  --------+---------+---------+---------+--------------------------------
//  input   | i_valid | o_stall | i_data  | one B element and one C element
//  output  | o_valid | i_stall | o_data  | one A element, row-major order
//
//  Schedule: one element is loaded per cycle while in the load phase; after the
//  DIM*DIM-th element each of the DIM*DIM results makes DIM passes through the
//  single complex MAC unit, goes through the read and product registers and
//  then takes one emit step, which waits while the output register is held.
//  Reset: i_rst_n low at a rising edge returns to loading at element 0; the
//  element stores are not cleared.
//  Stalls: o_stall is high from the last load until the last result enters
//  the output register; i_stall holds the output register and the emit step.
module complex_matrix_adjoint_product import cmadj_pkg::*; #(
    parameter int DIM = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_data
);

    localparam int AW = $clog2(DIM * DIM);

    // command and status between the sequencer and the arithmetic
    t_dp_cmd  cmd;
    t_dp_stat stat;
    logic [AW-1:0] waddr, raddr_b, raddr_c;

    // sequencer: counts loads, then walks i, j, k over the stores
    cmadj_ctrl #(.DIM(DIM)) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_stat    (stat),
        .o_cmd     (cmd),
        .o_waddr   (waddr),
        .o_raddr_b (raddr_b),
        .o_raddr_c (raddr_c)
    );

    // stores, four-multiplier complex MAC, saturation and output register
    cmadj_dp #(.DIM(DIM)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_data),
        .i_cmd     (cmd),
        .i_waddr   (waddr),
        .i_raddr_b (raddr_b),
        .i_raddr_c (raddr_c),
        .o_stat    (stat),
        .i_stall   (i_stall),
        .o_valid   (o_valid),
        .o_item    (o_data)
    );

endmodule

// ===== dv/complex_matrix_adjoint_product_tb.sv =====
// Self-checking testbench for the complex matrix adjoint product block.
module complex_matrix_adjoint_product_tb;
    import cmadj_pkg::*;

    localparam int DIM        = 3;
    localparam int ELEMS      = DIM * DIM;
    localparam int CLK_PERIOD = 8;
    localparam int RESET_CYC  = 12;
    localparam int RAND_MATS  = 50;           // about 450 random elements
    localparam int IDLE_PCT   = 7;
    localparam int CALM_FROM  = 1200;         // no random idling in this window
    localparam int CALM_TO    = 2000;
    localparam int HOLD_START = 300;          // receiver hold-off, in cycles after reset
    localparam int HOLD_LEN   = 150;
    localparam int DRAIN_CYC  = ELEMS * (DIM + 4);
    localparam int QUIET_MAX  = 2000;         // cycles without any transaction

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_ONE = 1 <<< FRAC_W;
    localparam longint SUM_MAX = (64'sd1 <<< (DATA_W - 1)) - 1;
    localparam longint SUM_MIN = -(64'sd1 <<< (DATA_W - 1));

    // Value classes for generated words
    typedef enum int {
        WORD_SMALL,      // within +/-1.0, keeps sums in range
        WORD_FULL,       // any 32-bit pattern
        WORD_EDGE,       // bounds, zero, +/-1 lsb, 1.0
        WORD_MIXED       // class picked per field
    } t_word_kind;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_item o_data;

    // Stimulus and scoreboard state
    t_in_item  element_feed[$];
    t_out_item product_queue[$];
    t_in_item  matrix_pair[ELEMS];           // B and C element, row-major
    int        fill_index;
    int        error_count;
    int        elems_loaded;
    int        elems_checked;
    int        clipped_seen;
    int        matrices_done;
    int        cycle_count;
    int        quiet_cycles;
    logic      in_taken;
    logic      hold_off;

    complex_matrix_adjoint_product #(
        .DIM (DIM)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $time, what);
        error_count++;
    endtask

    // One Q4.28 product, shifted back to Q4.28; >>> on a signed value floors.
    function automatic longint scaled_product(input longint a, input longint b);
        longint full;
        full = a * b;
        return full >>> FRAC_W;
    endfunction

    function automatic longint clamp_sum(input longint v);
        if (v > SUM_MAX) begin
            return SUM_MAX;
        end
        if (v < SUM_MIN) begin
            return SUM_MIN;
        end
        return v;
    endfunction

    // Store one element pair; on the last one of a matrix, queue every element
    // of A = B-dagger * C-dagger in row-major order.
    function automatic void load_matrix_element(input t_in_item item);
        longint re_sum, im_sum, re_clip, im_clip;
        longint br, bi, cr, ci;
        t_out_item res;
        matrix_pair[fill_index] = item;
        if (fill_index != ELEMS - 1) begin
            fill_index++;
            return;
        end
        fill_index = 0;
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                re_sum = 0;
                im_sum = 0;
                for (int k = 0; k < DIM; k++) begin
                    // conj(B[k][i]) * conj(C[j][k])
                    br = longint'(matrix_pair[k * DIM + i].b_real);
                    bi = longint'(matrix_pair[k * DIM + i].b_imag);
                    cr = longint'(matrix_pair[j * DIM + k].c_real);
                    ci = longint'(matrix_pair[j * DIM + k].c_imag);
                    re_sum += scaled_product(br, cr) - scaled_product(bi, ci);
                    im_sum -= scaled_product(br, ci) + scaled_product(bi, cr);
                end
                re_clip         = clamp_sum(re_sum);
                im_clip         = clamp_sum(im_sum);
                res.a_real      = DATA_W'(re_clip);
                res.a_imag      = DATA_W'(im_clip);
                res.last_result = (i == DIM - 1) && (j == DIM - 1);
                res.saturated   = (re_clip != re_sum) || (im_clip != im_sum);
                product_queue.push_back(res);
            end
        end
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_word(input t_word_kind kind);
        t_word_kind k;
        k = kind;
        if (k == WORD_MIXED) begin
            k = t_word_kind'($urandom_range(0, 2));
        end
        case (k)
            WORD_SMALL: begin
                return DATA_W'(longint'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
            end
            WORD_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return '1;
                    4: return 1;
                    default: return Q_ONE;
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic t_in_item make_element(input t_word_kind kind);
        t_in_item e;
        e.b_real = pick_word(kind);
        e.b_imag = pick_word(kind);
        e.c_real = pick_word(kind);
        e.c_imag = pick_word(kind);
        return e;
    endfunction

    function automatic t_word_kind pick_matrix_kind();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 4) begin
            return WORD_SMALL;
        end
        if (roll < 7) begin
            return WORD_FULL;
        end
        if (roll < 9) begin
            return WORD_EDGE;
        end
        return WORD_MIXED;
    endfunction

    function automatic logic random_idle();
        if (cycle_count >= CALM_FROM && cycle_count < CALM_TO) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < IDLE_PCT;
    endfunction

    // Sender: advance to the next element only once the current transaction
    // has gone through; otherwise hold the payload steady.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || in_taken) begin
                if (element_feed.size() != 0 && !random_idle()) begin
                    i_data  <= element_feed.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus the long hold-off that backs the block up
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_stall <= hold_off || random_idle();
        end
    end

    initial begin
        hold_off = 1'b0;
        @(posedge i_rst_n);
        repeat (HOLD_START) @(negedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_LEN) @(negedge i_clk);
        hold_off = 1'b0;
    end

    // Monitor: update the predictor on every accepted input, check every
    // accepted output against the oldest expected element, and watch for hangs.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            cycle_count <= cycle_count + 1;
            in_taken    <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                load_matrix_element(i_data);
                elems_loaded++;
            end
            if (o_valid && !i_stall) begin
                if (product_queue.size() == 0) begin
                    flag_mismatch("result element with nothing expected");
                end else begin
                    t_out_item want;
                    want = product_queue.pop_front();
                    if (o_data.a_real !== want.a_real) begin
                        flag_mismatch($sformatf("element %0d a_real got %h want %h",
                                      elems_checked, o_data.a_real, want.a_real));
                    end
                    if (o_data.a_imag !== want.a_imag) begin
                        flag_mismatch($sformatf("element %0d a_imag got %h want %h",
                                      elems_checked, o_data.a_imag, want.a_imag));
                    end
                    if (o_data.last_result !== want.last_result) begin
                        flag_mismatch($sformatf("element %0d last_result got %b want %b",
                                      elems_checked, o_data.last_result,
                                      want.last_result));
                    end
                    if (o_data.saturated !== want.saturated) begin
                        flag_mismatch($sformatf("element %0d saturated got %b want %b",
                                      elems_checked, o_data.saturated, want.saturated));
                    end
                    if (want.saturated) begin
                        clipped_seen++;
                    end
                    if (want.last_result) begin
                        matrices_done++;
                    end
                end
                elems_checked++;
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_MAX) begin
                $display("Watchdog: no transaction for %0d cycles, %0d elements pending",
                         QUIET_MAX, product_queue.size());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        t_in_item   e;
        t_word_kind kind;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_data        = '0;
        in_taken      = 1'b0;
        fill_index    = 0;
        error_count   = 0;
        elems_loaded  = 0;
        elems_checked = 0;
        clipped_seen  = 0;
        matrices_done = 0;
        cycle_count   = 0;
        quiet_cycles  = 0;

        // Most negative value everywhere: real parts cancel, imaginary parts
        // overflow far below the lower bound.
        for (int n = 0; n < ELEMS; n++) begin
            e = '{Q_MIN, Q_MIN, Q_MIN, Q_MIN};
            element_feed.push_back(e);
        end
        // Alternating bounds, zero and minus one lsb: clip both ways and
        // exercise floor rounding of tiny negative products.
        for (int n = 0; n < ELEMS; n++) begin
            if (n % 2 == 0) begin
                e = '{Q_MAX, Q_MIN, Q_MAX, Q_MAX};
            end else begin
                e = '{Q_MIN, Q_MAX, '0, '1};
            end
            element_feed.push_back(e);
        end
        // Random matrices, one value class per matrix
        for (int m = 0; m < RAND_MATS; m++) begin
            kind = pick_matrix_kind();
            for (int n = 0; n < ELEMS; n++) begin
                element_feed.push_back(make_element(kind));
            end
        end

        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every element sent, every result seen, then let the block settle
        while (element_feed.size() != 0 || i_valid) @(posedge i_clk);
        while (product_queue.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);

        if (product_queue.size() != 0) begin
            flag_mismatch($sformatf("%0d result elements never arrived",
                          product_queue.size()));
        end
        $display("Summary: %0d element pairs loaded, %0d matrix products checked",
                 elems_loaded, matrices_done);
        $display("Summary: %0d result elements compared, %0d of them clipped, %0d cycles",
                 elems_checked, clipped_seen, cycle_count);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/cmadj_pkg.sv
hdl/cmadj_ram.sv
hdl/cmadj_ctrl.sv
hdl/cmadj_dp.sv
hdl/complex_matrix_adjoint_product.sv
dv/complex_matrix_adjoint_product_tb.sv
